// ===== design/assert_macros.svh =====
// Assertion macros shared by the frame draw engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, masked while reset is asserted.
`define PFDE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("%m: check failed");
// Checked property, also evaluated across reset.
`define PFDE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define PFDE_ASSERT(lbl, clk, rstn, prop)
`define PFDE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== design/pfde_pkg.sv =====
// Types, constants and font table of the page frame draw engine.
package pfde_pkg;

  typedef enum logic [2:0] {
    OPC_CLEAR = 3'd0,
    OPC_POINT = 3'd1,
    OPC_LINE  = 3'd2,
    OPC_GLYPH = 3'd3,
    OPC_READ  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_DRAW,
    KIND_READ,
    KIND_NONE
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_STEP,
    ST_READ,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic rd;
    logic wr;
    logic clr_run;
    logic finish;
  } ctl_t;

  typedef struct packed {
    kind_t kind;
    logic  last;
    logic  clr_last;
  } sts_t;

  localparam int FIRST_CODE   = 32;
  localparam int LAST_CODE    = 126;
  localparam int GLYPHS       = 95;
  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_BYTES  = 16;
  localparam int CW           = 11;  // signed coordinate width
  localparam int EW           = 13;  // signed line error term width

  // Byte j of a glyph sits at bits [(15-j)*8 +: 8]; bytes 0..7 are the upper
  // half columns, bytes 8..15 the lower half.
  localparam logic [127:0] FONT_ROM [GLYPHS] = '{
    128'h00000000_00000000_00000000_00000000,
    128'h000000F8_00000000_00000033_00000000,
    128'h00100C02_100C0200_00000000_00000000,
    128'h0040C078_40C07800_00043F04_043F0400,
    128'h00708888_FC083000_00182020_FF211E00,
    128'hF008F080_60180000_00310C03_1E211E00,
    128'h00F00888_70000000_1E21232C_19272110,
    128'h00120E00_00000000_00000000_00000000,
    128'h000000E0_18040200_00000007_18204000,
    128'h00020418_E0000000_00402018_07000000,
    128'h404080F0_80404000_0202010F_01020200,
    128'h00000000_E0000000_00010101_0F010101,
    128'h00000000_00000000_00907000_00000000,
    128'h00000000_00000000_00010101_01010100,
    128'h00000000_00000000_00303000_00000000,
    128'h00000000_C0380400_00601807_00000000,
    128'h00E01008_0810E000_000F1020_20100F00,
    128'h00001010_F8000000_00002020_3F202000,
    128'h00700808_0808F000_00302824_22213000,
    128'h00300808_08887000_00182021_21221C00,
    128'h00008040_30F80000_00060524_243F2424,
    128'h00F88888_88080800_00192020_20110E00,
    128'h00E01088_88900000_000F1120_20201F00,
    128'h00180808_88681800_0000003E_01000000,
    128'h00708808_08887000_001C2221_21221C00,
    128'h00F00808_0810E000_00011222_22110F00,
    128'h000000C0_C0000000_00000030_30000000,
    128'h00000080_00000000_000000E0_00000000,
    128'h00008040_20100800_00010204_08102000,
    128'h00404040_40404000_00020202_02020200,
    128'h00081020_40800000_00201008_04020100,
    128'h00704808_08887000_00000030_37000000,
    128'hC030C828_E810E000_07182728_2F281700,
    128'h0000C038_E0000000_203C2302_02273820,
    128'h08F88888_88700000_203F2020_20110E00,
    128'hC0300808_08083800_07182020_20100800,
    128'h08F80808_0810E000_203F2020_20100F00,
    128'h08F88888_E8081000_203F2020_23201800,
    128'h08F88888_E8081000_203F2000_03000000,
    128'hC0300808_08380000_07182020_221E0200,
    128'h08F80800_0008F808_203F2101_01213F20,
    128'h000808F8_08080000_0020203F_20200000,
    128'h00000808_F8080800_C0808080_7F000000,
    128'h08F888C0_28180800_203F2001_26382000,
    128'h08F80800_00000000_203F2020_20203000,
    128'h08F8F800_F8F80800_203F013E_013F2000,
    128'h08F830C0_0008F808_203F2000_07183F00,
    128'hE0100808_0810E000_0F102020_20100F00,
    128'h08F80808_0808F000_203F2101_01010000,
    128'hE0100808_0810E000_0F102828_30504F00,
    128'h08F88888_88887000_203F2000_030C3020,
    128'h00708808_08083800_00382021_21221C00,
    128'h180808F8_08081800_0000203F_20000000,
    128'h08F80800_0008F808_001F2020_20201F00,
    128'h08788800_00C83808_00000738_0E010000,
    128'h08F800F8_00F80800_00033E01_3E030000,
    128'h08186880_80681808_20302C03_032C3020,
    128'h0838C800_C8380800_0000203F_20000000,
    128'h10080808_C8380800_20382621_20201800,
    128'h000000FE_02020200_0000007F_40404000,
    128'h000438C0_00000000_00000001_0638C000,
    128'h00020202_FE000000_00404040_7F000000,
    128'h00000402_02040000_00000000_00000000,
    128'h00000000_00000000_80808080_80808080,
    128'h00020204_00000000_00000000_00000000,
    128'h00008080_80000000_00192424_123F2000,
    128'h10F00080_80000000_003F1120_20110E00,
    128'h00000080_80800000_000E1120_20201100,
    128'h00008080_8090F000_001F2020_20103F20,
    128'h00008080_80800000_001F2424_24241700,
    128'h008080E0_90902000_0020203F_20200000,
    128'h00008080_80808000_006B9494_94936000,
    128'h10F00080_80800000_203F2100_00203F20,
    128'h00809898_00000000_0020203F_20200000,
    128'h00000080_98980000_00C08080_807F0000,
    128'h10F00000_80808000_203F2406_29302000,
    128'h001010F8_00000000_0020203F_20200000,
    128'h80808080_80808000_203F2000_3F20003F,
    128'h80800080_80800000_203F2100_00203F20,
    128'h00008080_80800000_001F2020_20201F00,
    128'h80800080_80000000_80FF9120_20110E00,
    128'h00000080_80008000_000E1120_2091FF80,
    128'h80808000_80808000_20203F21_20000100,
    128'h00008080_80808000_00332424_24241900,
    128'h008080E0_80800000_0000001F_20201000,
    128'h80800000_00808000_001F2020_20103F20,
    128'h80808000_80808000_00030C30_0C030000,
    128'h80800080_80008080_010E300C_07380601,
    128'h00808080_00808000_0020310E_2E312000,
    128'h80808000_00808080_00818678_18060100,
    128'h00808080_80808000_0021302C_22213000,
    128'h00000000_00FC0202_00000000_013E4040,
    128'h00000000_FF000000_00000000_FF000000,
    128'h0202FC00_00000000_40403E01_00000000,
    128'h00020102_02040200_00000000_00000000
  };

endpackage

// ===== design/pfde_if.sv =====
// Valid/ready channel interfaces for draw commands and their results.
interface pfde_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] x_start;
  logic [6:0] y_start;
  logic [7:0] x_end;
  logic [6:0] y_end;
  logic [7:0] glyph_code;
  logic [2:0] read_page;
  logic [7:0] read_column;

  modport source (
    output valid, command, x_start, y_start, x_end, y_end, glyph_code,
           read_page, read_column,
    input  ready
  );
  modport sink (
    input  valid, command, x_start, y_start, x_end, y_end, glyph_code,
           read_page, read_column,
    output ready
  );
endinterface

interface pfde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       rejected;

  modport source (output valid, read_data, rejected, input ready);
  modport sink (input valid, read_data, rejected, output ready);
endinterface

// ===== design/page_frame_draw_engine_unit.sv =====
// Top level of the page frame draw engine.
//
// Monochrome frame store of ROWS/8 pages by COLUMNS+1 byte columns. One
// command item arrives on in_chan (valid/ready); exactly one result item
// (read_data, rejected) leaves on out_chan for each accepted command.
// Items are processed one at a time; in_chan.ready is high only while idle.
// Each store byte touched is addressed, read and written back (ST_STEP,
// ST_READ, ST_WRITE) through the single read and single write port of the
// store RAM. A glyph touches 8 columns x 3 pages; a point is a line whose
// end is its start; a read byte is addressed and read, not written back.
// The result sits in an output register; a stalled receiver only holds up
// the next command once that command has its own result ready to hand off.
// Reset (rst_n low, synchronous) starts a clearing pass that writes zero to
// every store byte, one per cycle; no command is accepted until it completes.
`include "assert_macros.svh"

module page_frame_draw_engine_unit #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input logic        clk,
  input logic        rst_n,
  pfde_in_if.sink    in_chan,
  pfde_out_if.source out_chan
);
  pfde_pkg::ctl_t ctl;
  pfde_pkg::sts_t sts;
  logic           in_acc;
  logic           out_rej;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_rej = out_chan.valid && out_chan.rejected;

  pfde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  pfde_dp #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .command     (in_chan.command),
    .x_start     (in_chan.x_start),
    .y_start     (in_chan.y_start),
    .x_end       (in_chan.x_end),
    .y_end       (in_chan.y_end),
    .glyph_code  (in_chan.glyph_code),
    .read_page   (in_chan.read_page),
    .read_column (in_chan.read_column),
    .read_data   (out_chan.read_data),
    .rejected    (out_chan.rejected)
  );

  // Reset always leads into the clearing pass, never straight to idle.
  `PFDE_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !in_chan.ready)
  // One command at a time: an accepted item closes the input next cycle.
  `PFDE_ASSERT(a_one_at_a_time, clk, rst_n, in_acc |=> !in_chan.ready)
  // A refused command never returns store data.
  `PFDE_ASSERT(a_rej_no_data, clk, rst_n, out_rej |-> (out_chan.read_data == 8'h00))
endmodule

// ===== design/pfde_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1032
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== design/pfde_ctrl.sv =====
// Sequencer of the draw engine: clear sweep, per-byte read-modify-write, reply.
module pfde_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pfde_pkg::sts_t  sts,
  output pfde_pkg::ctl_t  ctl
);
  pfde_pkg::state_t state_r, state_nxt;
  logic reply_r, reply_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfde_pkg::ST_CLEAR;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfde_pkg::ST_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = reply_r ? pfde_pkg::ST_FINISH : pfde_pkg::ST_IDLE;
        end
      end
      pfde_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pfde_pkg::ST_DECODE;
        end
      end
      pfde_pkg::ST_DECODE: begin
        unique case (sts.kind)
          pfde_pkg::KIND_CLEAR: state_nxt = pfde_pkg::ST_CLEAR;
          pfde_pkg::KIND_DRAW,
          pfde_pkg::KIND_READ:  state_nxt = pfde_pkg::ST_STEP;
          default:              state_nxt = pfde_pkg::ST_FINISH;
        endcase
      end
      pfde_pkg::ST_STEP: state_nxt = pfde_pkg::ST_READ;
      pfde_pkg::ST_READ: begin
        state_nxt = (sts.kind == pfde_pkg::KIND_READ) ? pfde_pkg::ST_FINISH
                                                      : pfde_pkg::ST_WRITE;
      end
      pfde_pkg::ST_WRITE: begin
        state_nxt = sts.last ? pfde_pkg::ST_FINISH : pfde_pkg::ST_STEP;
      end
      pfde_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_nxt = pfde_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pfde_pkg::ST_IDLE;
    endcase
  end

  // reply flag and output valid
  always_comb begin
    reply_nxt     = reply_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (state_r == pfde_pkg::ST_DECODE) begin
      reply_nxt = 1'b1;
    end
    if ((state_r == pfde_pkg::ST_FINISH) && slot_free) begin
      reply_nxt     = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    unique case (state_r)
      pfde_pkg::ST_CLEAR:  ctl.clr_run = 1'b1;
      pfde_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      pfde_pkg::ST_DECODE: ctl.init = 1'b1;
      pfde_pkg::ST_STEP:   ctl.step = 1'b1;
      pfde_pkg::ST_READ:   ctl.rd   = 1'b1;
      pfde_pkg::ST_WRITE:  ctl.wr   = 1'b1;
      pfde_pkg::ST_FINISH: ctl.finish = slot_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
endmodule

// ===== design/pfde_dp.sv =====
// Datapath: command decode, line/glyph walkers, address and mask, frame store.
module pfde_dp #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pfde_pkg::ctl_t ctl,
  output pfde_pkg::sts_t sts,
  input  logic [2:0]     command,
  input  logic [7:0]     x_start,
  input  logic [6:0]     y_start,
  input  logic [7:0]     x_end,
  input  logic [6:0]     y_end,
  input  logic [7:0]     glyph_code,
  input  logic [2:0]     read_page,
  input  logic [7:0]     read_column,
  output logic [7:0]     read_data,
  output logic           rejected
);
  localparam int PAGES  = ROWS / 8;
  localparam int STRIDE = COLUMNS + 1;
  localparam int DEPTH  = PAGES * STRIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int RW     = $clog2(ROWS + 1);
  localparam int PW     = $clog2(PAGES + 3);
  localparam int CW     = pfde_pkg::CW;
  localparam int EW     = pfde_pkg::EW;

  // latched item
  logic [2:0] cmd_r;
  logic [7:0] xs_r, xe_r, code_r, rc_r;
  logic [6:0] ys_r, ye_r;
  logic [2:0] rp_r;

  // decode
  pfde_pkg::kind_t kind;
  logic rej, is_glyph;
  logic xs_bad, ys_bad, xe_bad, ye_bad, code_bad, rd_bad;

  // line walker
  logic                 walk_y_r, step_neg_r;
  logic signed [CW-1:0] major_r, minor0_r, q_r, n_r, i_r;
  logic signed [EW-1:0] rem_r, d2_r, den_r, rem_sum;
  logic signed [CW-1:0] sxs, sys, sxe, sye, dx, dy, adx, ady;
  logic                 walk_y;

  // glyph walker
  logic [2:0] gb_r;
  logic [1:0] gk_r;

  // pixel and address
  logic signed [CW-1:0] px, py, lrow, gcol, col_sel;
  logic                 line_hit, glyph_hit, hit_sel;
  logic [RW-1:0]        grow;
  logic [PW-1:0]        gpage, page_sel;
  logic [6:0]           gidx;
  logic [127:0]         font;
  logic [7:0]           v0, v1, gmask, mask_sel;
  logic [23:0]          gshift;
  logic [AW-1:0]        addr_sel;
  logic                 last_sel;

  logic [AW-1:0] addr_r;
  logic [7:0]    mask_r;
  logic          hit_r, last_r;

  // store
  logic [AW-1:0] clr_cnt_r;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [7:0] read_data_r;
  logic       rejected_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= command;
      xs_r   <= x_start;
      ys_r   <= y_start;
      xe_r   <= x_end;
      ye_r   <= y_end;
      code_r <= glyph_code;
      rp_r   <= read_page;
      rc_r   <= read_column;
    end
  end

  assign xs_bad   = int'(xs_r) > COLUMNS;
  assign ys_bad   = int'(ys_r) > ROWS;
  assign xe_bad   = int'(xe_r) > COLUMNS;
  assign ye_bad   = int'(ye_r) > ROWS;
  assign code_bad = (int'(code_r) < pfde_pkg::FIRST_CODE) ||
                    (int'(code_r) > pfde_pkg::LAST_CODE);
  assign rd_bad   = (int'(rp_r) >= PAGES) || (int'(rc_r) > COLUMNS);
  assign is_glyph = (cmd_r == pfde_pkg::OPC_GLYPH);

  always_comb begin
    kind = pfde_pkg::KIND_NONE;
    rej  = 1'b1;
    unique case (pfde_pkg::opcode_t'(cmd_r))
      pfde_pkg::OPC_CLEAR: begin
        kind = pfde_pkg::KIND_CLEAR;
        rej  = 1'b0;
      end
      pfde_pkg::OPC_POINT: rej = xs_bad || ys_bad;
      pfde_pkg::OPC_LINE:  rej = xs_bad || ys_bad || xe_bad || ye_bad;
      pfde_pkg::OPC_GLYPH: rej = xs_bad || ys_bad || code_bad;
      pfde_pkg::OPC_READ:  rej = rd_bad;
      default:             rej = 1'b1;
    endcase
    if (!rej) begin
      unique case (pfde_pkg::opcode_t'(cmd_r))
        pfde_pkg::OPC_CLEAR: kind = pfde_pkg::KIND_CLEAR;
        pfde_pkg::OPC_READ:  kind = pfde_pkg::KIND_READ;
        default:             kind = pfde_pkg::KIND_DRAW;
      endcase
    end
  end

  // line setup; a point is a line whose end is its start
  always_comb begin
    sxs = CW'(xs_r);
    sys = CW'(ys_r);
    sxe = (cmd_r == pfde_pkg::OPC_LINE) ? CW'(xe_r) : CW'(xs_r);
    sye = (cmd_r == pfde_pkg::OPC_LINE) ? CW'(ye_r) : CW'(ys_r);
    dx  = sxe - sxs;
    dy  = sye - sys;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    walk_y = (ady != 0) && (adx <= ady);
  end

  // current pixel of the line walker
  always_comb begin
    px = walk_y_r ? (minor0_r + q_r) : major_r;
    py = walk_y_r ? major_r : (minor0_r + q_r);
    lrow = CW'(ROWS) - py;
    line_hit = (py >= 1) && (py <= CW'(ROWS)) && (px >= 0) &&
               (px <= CW'(COLUMNS)) && ((lrow >>> 3) < CW'(PAGES));
  end

  // current byte of the glyph walker: three pages per column
  always_comb begin
    grow   = RW'(ROWS - int'(ys_r));
    gpage  = PW'(grow >> 3) + PW'(gk_r);
    gcol   = CW'(xs_r) + CW'(gb_r);
    glyph_hit = (int'(gpage) < PAGES) && (gcol <= CW'(COLUMNS));
    gidx   = 7'(code_r - 8'(pfde_pkg::FIRST_CODE));
    font   = pfde_pkg::FONT_ROM[gidx];
    v0     = font[(15 - int'(gb_r)) * 8 +: 8];
    v1     = font[(7 - int'(gb_r)) * 8 +: 8];
    gshift = 24'({v1, v0}) << grow[2:0];
    gmask  = gshift[int'(gk_r) * 8 +: 8];
  end

  always_comb begin
    if (kind == pfde_pkg::KIND_READ) begin
      page_sel = PW'(rp_r);
      col_sel  = CW'(rc_r);
      hit_sel  = 1'b1;
      mask_sel = 8'h00;
      last_sel = 1'b1;
    end else if (is_glyph) begin
      page_sel = gpage;
      col_sel  = gcol;
      hit_sel  = glyph_hit;
      mask_sel = gmask;
      last_sel = (gb_r == 3'(pfde_pkg::GLYPH_WIDTH - 1)) && (gk_r == 2'd2);
    end else begin
      page_sel = PW'(lrow >>> 3);
      col_sel  = px;
      hit_sel  = line_hit;
      mask_sel = 8'b1 << lrow[2:0];
      last_sel = (i_r == n_r);
    end
    addr_sel = AW'(int'(page_sel) * STRIDE + int'(col_sel));
  end

  assign rem_sum = rem_r + d2_r;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      walk_y_r   <= walk_y;
      major_r    <= walk_y ? sys : sxs;
      minor0_r   <= walk_y ? sxs : sys;
      step_neg_r <= walk_y ? (dy < 0) : (dx < 0);
      n_r        <= walk_y ? ady : adx;
      d2_r       <= walk_y ? (EW'(dx) <<< 1) : (EW'(dy) <<< 1);
      den_r      <= walk_y ? (EW'(ady) <<< 1) : (EW'(adx) <<< 1);
      rem_r      <= walk_y ? EW'(ady) : EW'(adx);
      q_r        <= '0;
      i_r        <= '0;
      gb_r       <= '0;
      gk_r       <= '0;
    end else if (ctl.step) begin
      addr_r  <= addr_sel;
      mask_r  <= mask_sel;
      hit_r   <= hit_sel;
      last_r  <= last_sel;
      i_r     <= i_r + CW'(1);
      major_r <= step_neg_r ? (major_r - CW'(1)) : (major_r + CW'(1));
      // nearest-integer minor coordinate, remainder kept in [0, den)
      if (rem_sum >= den_r) begin
        rem_r <= rem_sum - den_r;
        q_r   <= q_r + CW'(1);
      end else if (rem_sum < 0) begin
        rem_r <= rem_sum + den_r;
        q_r   <= q_r - CW'(1);
      end else begin
        rem_r <= rem_sum;
      end
      if (gk_r == 2'd2) begin
        gk_r <= 2'd0;
        gb_r <= gb_r + 3'd1;
      end else begin
        gk_r <= gk_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || !ctl.clr_run) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign ram_we    = ctl.clr_run || (ctl.wr && hit_r);
  assign ram_waddr = ctl.clr_run ? clr_cnt_r : addr_r;
  assign ram_wdata = ctl.clr_run ? 8'h00 : (ram_rdata | mask_r);

  pfde_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.rd),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      read_data_r <= (kind == pfde_pkg::KIND_READ) ? ram_rdata : 8'h00;
      rejected_r  <= rej;
    end
  end

  assign sts.kind     = kind;
  assign sts.last     = last_r;
  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));
  assign read_data    = read_data_r;
  assign rejected     = rejected_r;
endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the page frame draw engine: command driver, result monitor.
module tb_top;

  localparam int COLS   = 128;
  localparam int NROWS  = 64;
  localparam int NPAGES = NROWS / 8;
  localparam int STRIDE = COLS + 1;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] x_start;
    logic [6:0] y_start;
    logic [7:0] x_end;
    logic [6:0] y_end;
    logic [7:0] glyph_code;
    logic [2:0] read_page;
    logic [7:0] read_column;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rejected;
  } res_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pfde_in_if  cmd_ch ();
  pfde_out_if res_ch ();

  page_frame_draw_engine_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (cmd_ch.sink),
    .out_chan(res_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: shadow of the frame store.
  logic [7:0] shadow [NPAGES*STRIDE];
  cmd_item_t  pending_cmds [$];
  res_item_t  expected_res [$];
  int         err_count = 0;
  bit         no_idle = 0;      // stretch with no idling on either side
  bit         hold_out = 0;     // long receiver hold-off
  bit         hold_go = 0;
  bit         hold_done = 0;
  bit         pause_in = 0;     // sender pause until drained

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] exp);
    err_count++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
  endtask

  // Font byte j of a glyph, from the package table.
  function automatic logic [7:0] font_byte(input int idx, input int j);
    logic [127:0] g;
    g = pfde_pkg::FONT_ROM[idx];
    return g[(15-j)*8 +: 8];
  endfunction

  function automatic void or_into(input int page, input int col, input logic [7:0] m);
    if (page < 0 || page >= NPAGES || col < 0 || col > COLS) return;
    shadow[page*STRIDE+col] |= m;
  endfunction

  function automatic void set_pixel(input int x, input int y);
    int r;
    if (y < 1 || y > NROWS) return;
    r = NROWS - y;
    or_into(r >> 3, x, 8'(1 << (r & 7)));
  endfunction

  // Nearest integer of n/d, ties upward, d > 0.
  function automatic int nearest(input int n, input int d);
    int num, den, q;
    num = 2*n + d;
    den = 2*d;
    q = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    return q;
  endfunction

  function automatic void draw_segment(input int x0, input int y0, input int x1, input int y1);
    int dx, dy, adx, ady, s;
    dx = x1 - x0; dy = y1 - y0;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    if (ady != 0 && adx <= ady) begin
      s = dy < 0 ? -1 : 1;
      for (int i = 0; i <= ady; i++) set_pixel(x0 + nearest(dx*i, ady), y0 + s*i);
    end else begin
      s = dx < 0 ? -1 : 1;
      for (int i = 0; i <= adx; i++)
        set_pixel(x0 + s*i, adx == 0 ? y0 : y0 + nearest(dy*i, adx));
    end
  endfunction

  function automatic void stamp_glyph(input int x, input int y, input int code);
    int r, pg, sh;
    logic [15:0] v;
    r = NROWS - y; pg = r >> 3; sh = r & 7;
    for (int b = 0; b < 8; b++)
      for (int c = 0; c < 2; c++) begin
        v = 16'(font_byte(code - pfde_pkg::FIRST_CODE, b + c*8)) << sh;
        or_into(pg + c, x + b, v[7:0]);
        or_into(pg + c + 1, x + b, v[15:8]);
      end
  endfunction

  function automatic res_item_t predict_draw(input cmd_item_t c);
    res_item_t r;
    r = '0;
    case (c.command)
      pfde_pkg::OPC_CLEAR: foreach (shadow[i]) shadow[i] = 8'h00;
      pfde_pkg::OPC_POINT:
        if (c.x_start > COLS || c.y_start > NROWS) r.rejected = 1;
        else set_pixel(c.x_start, c.y_start);
      pfde_pkg::OPC_LINE:
        if (c.x_start > COLS || c.y_start > NROWS || c.x_end > COLS || c.y_end > NROWS)
          r.rejected = 1;
        else draw_segment(c.x_start, c.y_start, c.x_end, c.y_end);
      pfde_pkg::OPC_GLYPH:
        if (c.x_start > COLS || c.y_start > NROWS || c.glyph_code < pfde_pkg::FIRST_CODE ||
            c.glyph_code > pfde_pkg::LAST_CODE) r.rejected = 1;
        else stamp_glyph(c.x_start, c.y_start, c.glyph_code);
      pfde_pkg::OPC_READ:
        if (c.read_page >= NPAGES || c.read_column > COLS) r.rejected = 1;
        else r.read_data = shadow[c.read_page*STRIDE + c.read_column];
      default: r.rejected = 1;
    endcase
    return r;
  endfunction

  function automatic cmd_item_t rand_cmd();
    cmd_item_t c;
    int k;
    c = cmd_item_t'({$urandom, $urandom});
    k = $urandom_range(0, 99);
    // Mostly in-range operands, mostly draws and reads; clears rare (slow).
    if (k < 2) c.command = pfde_pkg::OPC_CLEAR;
    else if (k < 25) c.command = pfde_pkg::OPC_POINT;
    else if (k < 40) c.command = pfde_pkg::OPC_LINE;
    else if (k < 55) c.command = pfde_pkg::OPC_GLYPH;
    else if (k < 95) c.command = pfde_pkg::OPC_READ;
    else c.command = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) != 0) begin
      c.x_start = 8'($urandom_range(0, COLS));
      c.y_start = 7'($urandom_range(0, NROWS));
      c.x_end = 8'($urandom_range(0, COLS));
      c.y_end = 7'($urandom_range(0, NROWS));
      c.glyph_code = 8'($urandom_range(pfde_pkg::FIRST_CODE, pfde_pkg::LAST_CODE));
      c.read_page = 3'($urandom_range(0, NPAGES-1));
      c.read_column = 8'($urandom_range(0, COLS));
      // Short lines near the corner sometimes.
      if (c.command == pfde_pkg::OPC_LINE && $urandom_range(0, 3) != 0) begin
        c.x_end = 8'($urandom_range(0, 20)); c.y_end = 7'($urandom_range(0, 20));
        c.x_start = 8'($urandom_range(0, 20)); c.y_start = 7'($urandom_range(0, 20));
      end
    end
    return c;
  endfunction

  function automatic cmd_item_t mk(input logic [2:0] op, input int xs, input int ys,
                                   input int xe, input int ye, input int code,
                                   input int rp, input int rc);
    cmd_item_t c;
    c = '{op, 8'(xs), 7'(ys), 8'(xe), 7'(ye), 8'(code), 3'(rp), 8'(rc)};
    return c;
  endfunction

  // Driver: offers items from the pending queue; one NBA per signal per edge.
  // A waiting item stays offered until it is taken.
  always @(posedge clk) begin
    cmd_item_t nx;
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_res.push_back(predict_draw(pending_cmds.pop_front()));
      end
      if ((cmd_ch.valid && !cmd_ch.ready) ||
          (pending_cmds.size() > 0 && !pause_in &&
           (no_idle || $urandom_range(0, 99) >= 25))) begin
        nx = pending_cmds[0];
        cmd_ch.valid <= 1'b1;
        {cmd_ch.command, cmd_ch.x_start, cmd_ch.y_start, cmd_ch.x_end, cmd_ch.y_end,
         cmd_ch.glyph_code, cmd_ch.read_page, cmd_ch.read_column} <= nx;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest expectation.
  always @(posedge clk) begin
    res_item_t e;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_res.size() == 0) begin
          report("unexpected result", res_ch.read_data, 8'h00);
        end else begin
          e = expected_res.pop_front();
          if (res_ch.read_data !== e.read_data)
            report("read_data", res_ch.read_data, e.read_data);
          if (res_ch.rejected !== e.rejected)
            report("rejected", 8'(res_ch.rejected), 8'(e.rejected));
        end
      end
      res_ch.ready <= !hold_out && (no_idle || $urandom_range(0, 99) >= 25);
    end
  end

  // Receiver hold-off, counted in cycles once requested.
  initial begin
    wait (hold_go);
    hold_out = 1;
    repeat (600) @(posedge clk);
    hold_out = 0;
    hold_done = 1;
  end

  initial begin
    cmd_ch.valid = 1'b0;
    {cmd_ch.command, cmd_ch.x_start, cmd_ch.y_start, cmd_ch.x_end, cmd_ch.y_end,
     cmd_ch.glyph_code, cmd_ch.read_page, cmd_ch.read_column} = '0;
    res_ch.ready = 1'b0;
    foreach (shadow[i]) shadow[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every command, each clipping and refusal case.
    pending_cmds.push_back(mk(pfde_pkg::OPC_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(pfde_pkg::OPC_POINT, 0, 64, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(pfde_pkg::OPC_POINT, 128, 1, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(pfde_pkg::OPC_POINT, 5, 0, 0, 0, 0, 0, 0));      // clipped y
    pending_cmds.push_back(mk(pfde_pkg::OPC_POINT, 129, 10, 0, 0, 0, 0, 0));   // refused
    pending_cmds.push_back(mk(pfde_pkg::OPC_POINT, 255, 127, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(pfde_pkg::OPC_LINE, 0, 0, 128, 64, 0, 0, 0));
    pending_cmds.push_back(mk(pfde_pkg::OPC_LINE, 10, 60, 13, 50, 0, 0, 0));
    pending_cmds.push_back(mk(pfde_pkg::OPC_LINE, 7, 7, 7, 7, 0, 0, 0));
    pending_cmds.push_back(mk(pfde_pkg::OPC_LINE, 20, 5, 0, 6, 0, 0, 0));      // tie rounding
    pending_cmds.push_back(mk(pfde_pkg::OPC_LINE, 0, 0, 0, 65, 0, 0, 0));      // refused
    pending_cmds.push_back(mk(pfde_pkg::OPC_GLYPH, 0, 64, 0, 0, 65, 0, 0));
    pending_cmds.push_back(mk(pfde_pkg::OPC_GLYPH, 124, 3, 0, 0, 126, 0, 0));  // straddles
    pending_cmds.push_back(mk(pfde_pkg::OPC_GLYPH, 40, 30, 0, 0, 32, 0, 0));
    pending_cmds.push_back(mk(pfde_pkg::OPC_GLYPH, 40, 30, 0, 0, 31, 0, 0));   // bad code
    pending_cmds.push_back(mk(pfde_pkg::OPC_GLYPH, 40, 30, 0, 0, 255, 0, 0));
    pending_cmds.push_back(mk(pfde_pkg::OPC_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(pfde_pkg::OPC_READ, 0, 0, 0, 0, 0, 7, 128));
    pending_cmds.push_back(mk(pfde_pkg::OPC_READ, 0, 0, 0, 0, 0, 7, 129));     // refused
    pending_cmds.push_back(mk(pfde_pkg::OPC_READ, 0, 0, 0, 0, 0, 6, 124));
    pending_cmds.push_back(mk(3'd5, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(3'd7, 255, 127, 255, 127, 255, 7, 255));
    pending_cmds.push_back(mk(pfde_pkg::OPC_CLEAR, 255, 127, 255, 127, 255, 7, 255));
    pending_cmds.push_back(mk(pfde_pkg::OPC_READ, 0, 0, 0, 0, 0, 6, 124));
    wait (pending_cmds.size() == 0 && expected_res.size() == 0);

    // Sender pause mid-stream: nothing new offered until every result has arrived.
    for (int i = 0; i < 300; i++) pending_cmds.push_back(rand_cmd());
    wait (pending_cmds.size() < 200);
    pause_in = 1;
    wait (expected_res.size() == 0);
    pause_in = 0;
    wait (pending_cmds.size() == 0);

    // Long receiver hold-off while the sender keeps offering.
    for (int i = 0; i < 100; i++) pending_cmds.push_back(rand_cmd());
    hold_go = 1;
    wait (hold_done);

    no_idle = 1;
    for (int i = 0; i < 150; i++) pending_cmds.push_back(rand_cmd());
    wait (pending_cmds.size() == 0);
    no_idle = 0;
    for (int i = 0; i < 350; i++) pending_cmds.push_back(rand_cmd());
    wait (pending_cmds.size() == 0 && expected_res.size() == 0);
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("** page_frame_draw_engine_unit: PASSED **");
    end else begin
      $display("** page_frame_draw_engine_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #(12 * 6000000);
    $display("** page_frame_draw_engine_unit: FAILED **");
    $finish;
  end
endmodule
